// ===== hdl/srd_pkg.sv =====
// Package: shared types and constants of the sprite run decoder.
`timescale 1ns / 1ps

package srd_pkg;

    // Stream marker bytes
    localparam logic [7:0] END_MARK  = 8'd255;
    localparam logic [7:0] SKIP_MARK = 8'd254;

    // Configuration register indexes
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FRAME_COUNT  = 2'd2;

    // Reset values of the configuration registers
    localparam logic [8:0] RST_FRAME_WIDTH  = 9'd32;
    localparam logic [8:0] RST_FRAME_HEIGHT = 9'd40;
    localparam logic [8:0] RST_FRAME_COUNT  = 9'd1;

    // Decoder phases
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_DATA   = 2'd1;
    localparam logic [1:0] PH_COUNT  = 2'd2;

    // Clamped configuration as seen by the decoder
    typedef struct packed {
        logic [8:0] width;
        logic [8:0] height;
        logic [8:0] frames;
    } srd_cfg_t;

    // One result item
    typedef struct packed {
        logic [7:0]  frame_index;
        logic [15:0] start_offset;
        logic [16:0] run_length;
        logic [7:0]  run_value;
        logic        frame_end;
        logic        overflow;
    } srd_res_t;

endpackage

// ===== hdl/srd_if.sv =====
// Interfaces: coded byte channel and pixel run channel.
`timescale 1ns / 1ps

interface srd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface srd_run_if;
    logic        valid;
    logic        ready;
    logic [7:0]  frame_index;
    logic [15:0] start_offset;
    logic [16:0] run_length;
    logic [7:0]  run_value;
    logic        frame_end;
    logic        overflow;

    modport source (output valid, output frame_index, output start_offset,
                    output run_length, output run_value, output frame_end,
                    output overflow, input ready);
    modport sink   (input valid, input frame_index, input start_offset,
                    input run_length, input run_value, input frame_end,
                    input overflow, output ready);
endinterface

// ===== hdl/sprite_rle_run_decoder_core.sv =====
// Top level: run-length sprite stream decoder.
`timescale 1ns / 1ps

// Use:
//   in_ch carries one byte of the coded sprite stream per item. Each frame opens
//   with a header byte (whole transparent lines), then data bytes: 255 closes
//   the frame, 254 makes the next byte a transparent count, others are pixels.
//   out_ch carries pixel runs addressed by frame and linear offset; the frame
//   close gives a run of length zero with frame_end set.
//   Clipped runs carry overflow; empty runs and ignored bytes give no item.
//   The config port (cfg_we, cfg_index, cfg_wdata) sets width, height and frame
//   count; write it only while the block is idle.
// Timing:
//   A byte passes the byte register, then one pass of decode logic into the
//   result register. One item per cycle sustained while out_ch takes items;
//   the phase, offset and frame update is a loop through the decode logic.
// Reset:
//   Registers return to width 32, height 40, one frame; decoding restarts at
//   the header of frame 0 with offset 0. Both channels come up empty.
// Stall:
//   With out_ch stalled, the waiting result holds and the byte register takes
//   one more item, after which in_ch ready drops.

module sprite_rle_run_decoder_core #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_FRAMES = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    srd_byte_if.sink         in_ch,
    srd_run_if.source        out_ch,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [8:0]       cfg_wdata
);

    srd_pkg::srd_cfg_t cfg;
    srd_pkg::srd_res_t res;
    srd_pkg::srd_res_t out_reg;

    logic       in_vld_reg;
    logic [7:0] byte_reg;
    logic       out_vld_reg;
    logic       advance;
    logic       step;
    logic       emit;

    srd_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_FRAMES (MAX_FRAMES)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Result slot free or being emptied this cycle
    assign advance     = !out_vld_reg || out_ch.ready;
    assign step        = in_vld_reg && advance;
    assign in_ch.ready = !in_vld_reg || advance;

    srd_decode #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (byte_reg),
        .cfg       (cfg),
        .emit      (emit),
        .res       (res)
    );

    // Byte register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_ch.ready)
            in_vld_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
            byte_reg <= in_ch.data_byte;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= step && emit;
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
            out_reg <= res;
    end

    assign out_ch.valid        = out_vld_reg;
    assign out_ch.frame_index  = out_reg.frame_index;
    assign out_ch.start_offset = out_reg.start_offset;
    assign out_ch.run_length   = out_reg.run_length;
    assign out_ch.run_value    = out_reg.run_value;
    assign out_ch.frame_end    = out_reg.frame_end;
    assign out_ch.overflow     = out_reg.overflow;

endmodule

// ===== hdl/srd_cfg.sv =====
// Configuration registers with clamping to the supported ranges.
`timescale 1ns / 1ps

module srd_cfg #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_FRAMES = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [8:0]        cfg_wdata,
    output srd_pkg::srd_cfg_t cfg
);

    // Registers are 9 bits, so no clamped value exceeds 511
    localparam int W_LIM = (MAX_WIDTH  < 511) ? MAX_WIDTH  : 511;
    localparam int H_LIM = (MAX_HEIGHT < 511) ? MAX_HEIGHT : 511;
    localparam int F_LIM = (MAX_FRAMES < 511) ? MAX_FRAMES : 511;

    logic [8:0] width_reg;
    logic [8:0] height_reg;
    logic [8:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= srd_pkg::RST_FRAME_WIDTH;
            height_reg <= srd_pkg::RST_FRAME_HEIGHT;
            count_reg  <= srd_pkg::RST_FRAME_COUNT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                srd_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg_wdata;
                srd_pkg::REG_FRAME_HEIGHT: height_reg <= cfg_wdata;
                srd_pkg::REG_FRAME_COUNT:  count_reg  <= cfg_wdata;
                default:                   ;
            endcase
        end
    end

    function automatic logic [8:0] clamp9(input logic [8:0] v, input logic [8:0] hi);
        logic [8:0] r;
        begin
            if (v == 9'd0)
                r = 9'd1;
            else if (v > hi)
                r = hi;
            else
                r = v;
            return r;
        end
    endfunction

    always_comb
    begin
        cfg.width  = clamp9(width_reg,  9'(W_LIM));
        cfg.height = clamp9(height_reg, 9'(H_LIM));
        cfg.frames = clamp9(count_reg,  9'(F_LIM));
    end

endmodule

// ===== hdl/srd_decode.sv =====
// Decoder state and the single-pass byte-to-run logic.
`timescale 1ns / 1ps

module srd_decode #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  srd_pkg::srd_cfg_t cfg,
    output logic              emit,
    output srd_pkg::srd_res_t res
);

    localparam int W_LIM = (MAX_WIDTH  < 511) ? MAX_WIDTH  : 511;
    localparam int H_LIM = (MAX_HEIGHT < 511) ? MAX_HEIGHT : 511;
    // Offset never exceeds the largest area
    localparam int OFF_W = $clog2(W_LIM * H_LIM + 1);

    logic [1:0]       phase_reg,  phase_next;
    logic [OFF_W-1:0] offset_reg, offset_next;
    logic [8:0]       frame_reg,  frame_next;

    logic [16:0]      hdr_len;
    logic [17:0]      area_full;
    logic [OFF_W-1:0] area;
    logic [OFF_W-1:0] left;
    logic [17:0]      req_len;
    logic [17:0]      clip_len;
    logic             clipped;
    logic             run_req;
    logic             fend;
    logic [7:0]       run_val;
    logic [17:0]      off_ext;

    assign hdr_len   = {9'd0, data_byte} * {8'd0, cfg.width};
    assign area_full = {9'd0, cfg.width} * {9'd0, cfg.height};
    assign area      = area_full[OFF_W-1:0];
    assign left      = (offset_reg < area) ? (area - offset_reg) : '0;
    assign clipped   = req_len > 18'(left);
    assign clip_len  = clipped ? 18'(left) : req_len;
    assign off_ext   = 18'(offset_reg);

    always_comb
    begin
        phase_next = phase_reg;
        frame_next = frame_reg;
        run_req    = 1'b0;
        fend       = 1'b0;
        req_len    = '0;
        run_val    = '0;
        if (frame_reg < cfg.frames)
        begin
            case (phase_reg)
                srd_pkg::PH_HEADER:
                begin
                    phase_next = srd_pkg::PH_DATA;
                    run_req    = 1'b1;
                    req_len    = 18'(hdr_len);
                end
                srd_pkg::PH_COUNT:
                begin
                    phase_next = srd_pkg::PH_DATA;
                    run_req    = 1'b1;
                    req_len    = 18'(data_byte);
                end
                srd_pkg::PH_DATA:
                begin
                    if (data_byte == srd_pkg::END_MARK)
                    begin
                        fend       = 1'b1;
                        phase_next = srd_pkg::PH_HEADER;
                        frame_next = frame_reg + 9'd1;
                    end
                    else if (data_byte == srd_pkg::SKIP_MARK)
                        phase_next = srd_pkg::PH_COUNT;
                    else
                    begin
                        run_req = 1'b1;
                        req_len = 18'd1;
                        run_val = data_byte;
                    end
                end
                default:
                    phase_next = srd_pkg::PH_HEADER;
            endcase
        end
    end

    always_comb
    begin
        if (fend)
            offset_next = '0;
        else if (run_req)
            offset_next = offset_reg + clip_len[OFF_W-1:0];
        else
            offset_next = offset_reg;
    end

    assign emit = fend || (run_req && (clip_len != 18'd0));

    always_comb
    begin
        res.frame_index  = frame_reg[7:0];
        res.start_offset = off_ext[15:0];
        res.run_length   = fend ? 17'd0 : clip_len[16:0];
        res.run_value    = fend ? 8'd0 : run_val;
        res.frame_end    = fend;
        res.overflow     = !fend && run_req && clipped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= srd_pkg::PH_HEADER;
            offset_reg <= '0;
            frame_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            frame_reg  <= frame_next;
        end
    end

endmodule

// ===== hdl/srd_checker.sv =====
// Port-level checker for the sprite run decoder, with its bind.
`timescale 1ns / 1ps

module srd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [16:0] run_length,
    input logic [7:0]  run_value,
    input logic [15:0] start_offset,
    input logic        frame_end,
    input logic        overflow
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(run_length)
            && $stable(start_offset) && $stable(frame_end))
        else $error("result changed while stalled");

    // Frame close carries no pixels
    a_fend_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> run_length == 17'd0 && run_value == 8'd0
            && !overflow)
        else $error("frame end item carries a run");

    // Pixel runs are never empty
    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_end |-> run_length != 17'd0)
        else $error("empty run delivered");

endmodule

bind sprite_rle_run_decoder_core srd_checker u_srd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .run_length   (out_ch.run_length),
    .run_value    (out_ch.run_value),
    .start_offset (out_ch.start_offset),
    .frame_end    (out_ch.frame_end),
    .overflow     (out_ch.overflow)
);

// ===== test/tb_sprite_rle_run_decoder_core.sv =====
// Testbench: sprite run decoder checked against an in-bench decode of the byte stream.
`timescale 1ns / 1ps

module tb_sprite_rle_run_decoder_core;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 9;
    localparam int W_MAX        = 256;
    localparam int H_MAX        = 256;
    localparam int FRAMES_MAX   = 256;
    localparam int ITEM_TARGET  = 1550;   // bytes sent in the random part
    localparam int DRAIN_CYCLES = 6;      // wait after the owed runs are all out
    localparam int TAIL_CYCLES  = 8;
    localparam int HOLD_CYCLES  = 300;    // long output stall for back-pressure
    localparam int WATCHDOG     = 2000;   // cycles with no item moving on either side
    localparam int PRINT_CAP    = 100;

    // Index with no register behind it: the block must ignore writes to it.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // How a directed row is checked: by the in-bench decoder, as giving no run,
    // against a run typed into the table, or as a register write.
    typedef enum logic [1:0] {ROW_MODEL, ROW_QUIET, ROW_RUN, ROW_CFG} row_kind_e;

    typedef struct packed {
        row_kind_e         kind;
        logic [1:0]        idx;
        logic [8:0]        value;    // stream byte in the low bits, or register data
        srd_pkg::srd_res_t run;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [8:0] cfg_wdata;

    srd_byte_if in_if();
    srd_run_if  out_if();

    sprite_rle_run_decoder_core #(
        .MAX_WIDTH  (W_MAX),
        .MAX_HEIGHT (H_MAX),
        .MAX_FRAMES (FRAMES_MAX)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_if),
        .out_ch    (out_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Decoder state mirrored in the bench. Registers hold the raw written
    // value; clamping happens at use, as in the block.
    // ------------------------------------------------------------------
    logic [8:0]  cfg_width;
    logic [8:0]  cfg_height;
    logic [8:0]  cfg_count;
    logic [1:0]  dec_phase;
    logic [16:0] dec_offset;
    logic [8:0]  dec_frame;

    srd_pkg::srd_res_t run_expect_q[$];     // runs still owed by the block, oldest first
    stim_row_t         dir_rows[$];

    row_kind_e         pin_kind = ROW_MODEL;
    srd_pkg::srd_res_t pin_run  = '0;
    int          error_count = 0;
    int          sent_items  = 0;     // bytes taken by the block
    int          idle_cycles = 0;
    int          idle_pct    = 16;
    logic        hold_req    = 1'b0;

    function automatic int unsigned clamp_reg(logic [8:0] v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic srd_pkg::srd_res_t run_item(int unsigned frame, int unsigned off,
                                                   int unsigned len, int unsigned val,
                                                   bit fend, bit ovf);
        srd_pkg::srd_res_t r;
        r.frame_index  = 8'(frame);
        r.start_offset = 16'(off);
        r.run_length   = 17'(len);
        r.run_value    = 8'(val);
        r.frame_end    = fend;
        r.overflow     = ovf;
        return r;
    endfunction

    function automatic void row_byte(row_kind_e k, logic [7:0] b, srd_pkg::srd_res_t r);
        stim_row_t row;
        row.kind  = k;
        row.idx   = '0;
        row.value = {1'b0, b};
        row.run   = r;
        dir_rows.push_back(row);
    endfunction

    function automatic void row_cfg(logic [1:0] idx, logic [8:0] v);
        stim_row_t row;
        row.kind  = ROW_CFG;
        row.idx   = idx;
        row.value = v;
        row.run   = '0;
        dir_rows.push_back(row);
    endfunction

    // Decode one stream byte: nothing happens once every frame is done;
    // 'got' is high when the byte yields a run.
    task automatic decode_byte(input logic [7:0] b, output bit got,
                               output srd_pkg::srd_res_t r);
        int unsigned w, h, frames, area, left, len;
        logic [7:0] val;
        bit clipped;
        w      = clamp_reg(cfg_width, W_MAX);
        h      = clamp_reg(cfg_height, H_MAX);
        frames = clamp_reg(cfg_count, FRAMES_MAX);
        area   = w * h;
        got    = 1'b0;
        r      = '0;
        len    = 0;
        val    = '0;
        if (dec_frame >= frames) return;
        case (dec_phase)
            srd_pkg::PH_HEADER:
            begin
                // header: whole transparent lines
                dec_phase = srd_pkg::PH_DATA;
                len = b * w;
            end
            srd_pkg::PH_COUNT:
            begin
                // after a skip marker the next byte is a count, markers included
                dec_phase = srd_pkg::PH_DATA;
                len = b;
            end
            default:
            begin
                if (b == srd_pkg::END_MARK)
                begin
                    r = run_item(dec_frame, dec_offset, 0, 0, 1'b1, 1'b0);
                    got = 1'b1;
                    dec_frame  = dec_frame + 9'd1;
                    dec_offset = '0;
                    dec_phase  = srd_pkg::PH_HEADER;
                    return;
                end
                if (b == srd_pkg::SKIP_MARK)
                begin
                    dec_phase = srd_pkg::PH_COUNT;
                    return;
                end
                len = 1;
                val = b;
            end
        endcase
        // clip at the end of the frame area; nothing left means no run
        left    = (dec_offset < area) ? area - dec_offset : 0;
        clipped = (len > left);
        if (clipped) len = left;
        if (len == 0) return;
        r = run_item(dec_frame, dec_offset, len, val, 1'b0, clipped);
        got = 1'b1;
        dec_offset = dec_offset + 17'(len);
    endtask

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_CAP)
            $display("[%0t] ERROR %s", $time, msg);
        error_count++;
    endtask

    task automatic compare_run(input srd_pkg::srd_res_t seen, input srd_pkg::srd_res_t want);
        if (seen.frame_index !== want.frame_index)
            report_mismatch($sformatf("frame_index got %0d expected %0d",
                                      seen.frame_index, want.frame_index));
        if (seen.start_offset !== want.start_offset)
            report_mismatch($sformatf("start_offset got %0d expected %0d",
                                      seen.start_offset, want.start_offset));
        if (seen.run_length !== want.run_length)
            report_mismatch($sformatf("run_length got %0d expected %0d",
                                      seen.run_length, want.run_length));
        if (seen.run_value !== want.run_value)
            report_mismatch($sformatf("run_value got %0d expected %0d",
                                      seen.run_value, want.run_value));
        if (seen.frame_end !== want.frame_end)
            report_mismatch($sformatf("frame_end got %0b expected %0b",
                                      seen.frame_end, want.frame_end));
        if (seen.overflow !== want.overflow)
            report_mismatch($sformatf("overflow got %0b expected %0b",
                                      seen.overflow, want.overflow));
    endtask

    // ------------------------------------------------------------------
    // Monitor, sampled at the rising edge. Output items are checked before
    // the input item of the same edge is decoded; with the byte and result
    // registers between them the two can never belong together.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        srd_pkg::srd_res_t seen;
        srd_pkg::srd_res_t pred;
        bit got;
        bit moved;
        moved = 1'b0;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            moved = 1'b1;
            seen.frame_index  = out_if.frame_index;
            seen.start_offset = out_if.start_offset;
            seen.run_length   = out_if.run_length;
            seen.run_value    = out_if.run_value;
            seen.frame_end    = out_if.frame_end;
            seen.overflow     = out_if.overflow;
            if (run_expect_q.size() == 0)
                report_mismatch($sformatf("run item with none expected: frame %0d off %0d",
                                          seen.frame_index, seen.start_offset));
            else
                compare_run(seen, run_expect_q.pop_front());
        end
        if (rst_n && in_if.valid && in_if.ready)
        begin
            moved = 1'b1;
            decode_byte(in_if.data_byte, got, pred);
            sent_items++;
            case (pin_kind)
                ROW_RUN:   run_expect_q.push_back(pin_run);
                ROW_QUIET: ;
                default:   if (got) run_expect_q.push_back(pred);
            endcase
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Output side: random stalls at the falling edge, plus one long hold
    // when asked for, so the block fills and drops in_ch ready.
    // ------------------------------------------------------------------
    initial
    begin
        out_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_if.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            out_if.ready = ($urandom_range(99) >= idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Input side. All driving happens at the falling edge; a task returns
    // at the falling edge after its item was taken, valid still high.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            in_if.valid = 1'b0;
            @(negedge clk);
        end
        in_if.valid     = 1'b1;
        in_if.data_byte = b;
        do
            @(posedge clk);
        while (!in_if.ready);
        @(negedge clk);
    endtask

    // Stop offering and let every owed run, and any byte that gives none,
    // clear the pipeline before registers are touched.
    task automatic drain_pipeline();
        in_if.valid = 1'b0;
        while (run_expect_q.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [8:0] v);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            srd_pkg::REG_FRAME_WIDTH:  cfg_width  = v;
            srd_pkg::REG_FRAME_HEIGHT: cfg_height = v;
            srd_pkg::REG_FRAME_COUNT:  cfg_count  = v;
            default: ;
        endcase
    endtask

    // Sizes: mostly small so that clipping is common, sometimes the extremes
    // and the out-of-range values that clamp.
    function automatic logic [8:0] pick_size();
        case ($urandom_range(9))
            0:       return 9'd0;
            1:       return 9'd511;
            2:       return 9'd256;
            3:       return 9'd1;
            default: return 9'($urandom_range(1, 24));
        endcase
    endfunction

    // Mostly a count ahead of the current frame; now and then one at or
    // below it, so the stream is ignored for a while.
    function automatic logic [8:0] pick_count();
        if ($urandom_range(7) == 0)
            return 9'($urandom_range(0, dec_frame));
        return dec_frame + 9'($urandom_range(1, 12));
    endfunction

    // One frame with random content: header, pixels, skip/count pairs and a
    // little noise; the end marker is sometimes left out.
    task automatic send_frame();
        int n;
        int pick;
        if ($urandom_range(3) == 0)
            send_byte(8'($urandom_range(255)));
        else
            send_byte(8'($urandom_range(3)));
        n = $urandom_range(1, 24);
        repeat (n)
        begin
            pick = $urandom_range(9);
            if (pick < 6)
                send_byte(8'($urandom_range(253)));
            else if (pick < 9)
            begin
                send_byte(srd_pkg::SKIP_MARK);
                if ($urandom_range(1) == 0)
                    send_byte(8'($urandom_range(8)));
                else
                    send_byte(8'($urandom_range(255)));
            end
            else
                send_byte(8'($urandom_range(255)));
        end
        if ($urandom_range(7) != 0)
            send_byte(srd_pkg::END_MARK);
    endtask

    initial
    begin
        int stage;
        int n_frames;
        in_if.valid     = 1'b0;
        in_if.data_byte = '0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_wdata       = '0;
        rst_n           = 1'b0;

        cfg_width  = srd_pkg::RST_FRAME_WIDTH;
        cfg_height = srd_pkg::RST_FRAME_HEIGHT;
        cfg_count  = srd_pkg::RST_FRAME_COUNT;
        dec_phase  = srd_pkg::PH_HEADER;
        dec_offset = '0;
        dec_frame  = '0;

        // Directed stream. Reset sizes: 32 x 40, one frame, area 1280.
        row_byte(ROW_QUIET, 8'd0,   '0);                                  // empty header
        row_byte(ROW_RUN,   8'd0,   run_item(0, 0, 1, 0, 0, 0));          // pixel value 0
        row_byte(ROW_RUN,   8'd253, run_item(0, 1, 1, 253, 0, 0));        // top pixel value
        row_byte(ROW_QUIET, srd_pkg::SKIP_MARK, '0);
        row_byte(ROW_RUN,   8'd255, run_item(0, 2, 255, 0, 0, 0));        // end marker as count
        row_byte(ROW_QUIET, srd_pkg::SKIP_MARK, '0);
        row_byte(ROW_RUN,   8'd254, run_item(0, 257, 254, 0, 0, 0));      // skip marker as count
        row_byte(ROW_QUIET, srd_pkg::SKIP_MARK, '0);
        row_byte(ROW_QUIET, 8'd0,   '0);                                  // empty count
        row_byte(ROW_MODEL, 8'd128, '0);
        row_byte(ROW_RUN,   srd_pkg::END_MARK, run_item(0, 512, 0, 0, 1, 0));
        row_byte(ROW_QUIET, 8'h5A,  '0);                                  // all frames done
        row_cfg(srd_pkg::REG_FRAME_COUNT, 9'd3);                          // resumes at frame 1
        row_byte(ROW_RUN,   8'd1,   run_item(1, 0, 32, 0, 0, 0));
        row_byte(ROW_MODEL, 8'd127, '0);
        row_cfg(srd_pkg::REG_FRAME_WIDTH, 9'd0);                          // clamps to 1, area 40
        row_byte(ROW_QUIET, srd_pkg::SKIP_MARK, '0);
        row_byte(ROW_RUN,   8'd10,  run_item(1, 33, 7, 0, 0, 1));         // clipped
        row_byte(ROW_QUIET, 8'd5,   '0);                                  // area full
        row_byte(ROW_RUN,   srd_pkg::END_MARK, run_item(1, 40, 0, 0, 1, 0));
        row_cfg(srd_pkg::REG_FRAME_WIDTH, 9'd511);                        // both clamp to 256
        row_cfg(srd_pkg::REG_FRAME_HEIGHT, 9'd300);
        row_byte(ROW_RUN,   8'd255, run_item(2, 0, 65280, 0, 0, 0));      // largest header
        row_byte(ROW_QUIET, srd_pkg::SKIP_MARK, '0);
        row_byte(ROW_RUN,   8'd255, run_item(2, 65280, 255, 0, 0, 0));
        row_byte(ROW_RUN,   8'd253, run_item(2, 65535, 1, 253, 0, 0));    // last pixel of area
        row_byte(ROW_RUN,   srd_pkg::END_MARK, run_item(2, 0, 0, 0, 1, 0)); // offset wraps
        row_cfg(REG_UNUSED, 9'h1FF);                                      // no such register
        row_cfg(srd_pkg::REG_FRAME_COUNT, 9'd0);                          // clamps to 1
        row_byte(ROW_QUIET, 8'h3C,  '0);
        row_cfg(srd_pkg::REG_FRAME_COUNT, 9'd511);                        // clamps to 256
        row_cfg(srd_pkg::REG_FRAME_WIDTH, 9'd1);
        row_cfg(srd_pkg::REG_FRAME_HEIGHT, 9'd0);                         // area 1
        row_byte(ROW_RUN,   8'd3,   run_item(3, 0, 1, 0, 0, 1));
        row_byte(ROW_QUIET, 8'd7,   '0);

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                drain_pipeline();
                write_reg(dir_rows[i].idx, dir_rows[i].value);
            end
            else
            begin
                pin_kind = dir_rows[i].kind;
                pin_run  = dir_rows[i].run;
                send_byte(dir_rows[i].value[7:0]);
            end
        end
        drain_pipeline();
        pin_kind   = ROW_MODEL;
        sent_items = 0;

        // Random stages: fresh sizes and frame count each time, then a batch
        // of frames. Stage 3 runs with no idling at all; stage 5 opens with a
        // long output hold while bytes keep coming, with frames left to decode.
        stage = 0;
        while (sent_items < ITEM_TARGET)
        begin
            drain_pipeline();
            write_reg(srd_pkg::REG_FRAME_WIDTH, pick_size());
            write_reg(srd_pkg::REG_FRAME_HEIGHT, pick_size());
            write_reg(srd_pkg::REG_FRAME_COUNT,
                      (stage == 5) ? dec_frame + 9'd8 : pick_count());
            idle_pct = (stage == 3) ? 0 : 16;
            if (stage == 5) hold_req = 1'b1;
            n_frames = (stage == 3) ? 20 : $urandom_range(2, 8);
            repeat (n_frames) send_frame();
            stage++;
        end

        drain_pipeline();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/srd_pkg.sv
hdl/srd_if.sv
hdl/srd_cfg.sv
hdl/srd_decode.sv
hdl/sprite_rle_run_decoder_core.sv
hdl/srd_checker.sv
test/tb_sprite_rle_run_decoder_core.sv
